/* rtl/itps_pkg.sv */
// Shared widths, constants and controller/datapath interface types for the smoothing unit.
package itps_pkg;

   // Default vector capacity
   localparam int MAX_LEN_DEFAULT = 64;

   // Fixed field widths
   localparam int SAMPLE_W = 23;
   localparam int RSUM_W   = 29;
   localparam int SWEEP_W  = 10;

   // Three-point sum and divide-by-three reciprocal: floor(x / 3) = (x * RECIP3) >> RECIP_SHIFT
   // holds for every x below 2**RECIP_SHIFT, which covers the whole three-point sum.
   localparam int SUM3_W      = SAMPLE_W + 2;
   localparam int RECIP_W     = 26;
   localparam int RECIP_SHIFT = 27;
   localparam logic [RECIP_W-1:0] RECIP3 = 26'd44739243;
   localparam int PROD_W      = SUM3_W + RECIP_W;

   localparam logic [SWEEP_W-1:0] SWEEP_RESET = 10'd1;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_wr;     // store the accepted sample at the load index
      logic ovf_set;     // sample dropped, vector overflowed
      logic step;        // one sweep step (read or flush)
      logic step_first;  // step for element zero, no result yet
      logic step_flush;  // trailing step, no read
      logic emit;        // read one element toward the result channel
      logic emit_last;   // final element of the vector
      logic bank;        // bank holding the current vector
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic pipe_busy;   // sweep pipeline still holds steps
      logic emit_ok;     // result register can take another element
   } stat_type;

endpackage

/* rtl/itps_ctrl.sv */
// Sequencer for load, sweep and emit phases of the smoothing unit.
module itps_ctrl #(
   parameter int MAX_LEN = itps_pkg::MAX_LEN_DEFAULT,
   parameter int IDX_W   = $clog2(MAX_LEN),
   parameter int CNT_W   = $clog2(MAX_LEN + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_last_in,
   input  logic                          csr_we,
   input  logic [itps_pkg::SWEEP_W-1:0]  csr_wdata,
   input  itps_pkg::stat_type            stat,
   output itps_pkg::cmd_type             cmd,
   output logic [IDX_W-1:0]              ctl_idx
);
   import itps_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

   state_type            state_ff, state_in;
   logic [SWEEP_W-1:0]   sweep_cfg_ff, sweep_cfg_in;
   logic [SWEEP_W-1:0]   sweep_left_ff, sweep_left_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]     out_ff, out_in;
   logic                 bank_ff, bank_in;
   logic                 accept;
   logic                 room;
   logic [CNT_W-1:0]     n_next;

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign room      = (count_ff < CNT_MAX);
   assign n_next    = room ? count_ff + CNT_ONE : count_ff;

   // Sweep count register
   always_comb begin
      sweep_cfg_in = csr_we ? csr_wdata : sweep_cfg_ff;
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      sweep_left_in = sweep_left_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      out_in        = out_ff;
      bank_in       = bank_ff;
      cmd           = '0;
      cmd.bank      = bank_ff;
      ctl_idx       = '0;
      unique case (state_ff)
         ST_LOAD: begin
            ctl_idx = count_ff[IDX_W-1:0];
            if (accept) begin
               cmd.load_wr = room;
               cmd.ovf_set = !room;
               count_in    = n_next;
               if (req_last_in) begin
                  sweep_left_in = sweep_cfg_ff;
                  step_in       = '0;
                  out_in        = '0;
                  if ((n_next >= CNT_TWO) && (sweep_cfg_ff != '0)) begin
                     state_in = ST_SWEEP;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_SWEEP: begin
            // Issue one step per cycle, then a flush step past the end
            ctl_idx        = step_ff[IDX_W-1:0];
            cmd.step       = 1'b1;
            cmd.step_first = (step_ff == '0);
            cmd.step_flush = (step_ff == count_ff);
            step_in        = step_ff + CNT_ONE;
            if (step_ff == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Wait for the last write, then swap banks
            if (!stat.pipe_busy) begin
               bank_in = !bank_ff;
               step_in = '0;
               if (sweep_left_ff == SWEEP_W'(1)) begin
                  state_in = ST_EMIT;
               end else begin
                  sweep_left_in = sweep_left_ff - SWEEP_W'(1);
                  state_in      = ST_SWEEP;
               end
            end
         end
         ST_EMIT: begin
            ctl_idx = out_ff[IDX_W-1:0];
            if (stat.emit_ok) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = (out_ff == count_ff - CNT_ONE);
               out_in        = out_ff + CNT_ONE;
               if (out_ff == count_ff - CNT_ONE) begin
                  count_in = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         sweep_cfg_ff  <= SWEEP_RESET;
         sweep_left_ff <= '0;
         count_ff      <= '0;
         step_ff       <= '0;
         out_ff        <= '0;
         bank_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_cfg_ff  <= sweep_cfg_in;
         sweep_left_ff <= sweep_left_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         out_ff        <= out_in;
         bank_ff       <= bank_in;
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("element count past capacity");

   a_sweep_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (count_ff >= CNT_TWO))
      else $error("sweep started on a vector shorter than two");

   a_sweep_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (sweep_left_ff != '0))
      else $error("drain with no sweep pending");

endmodule

/* rtl/itps_dp.sv */
// Datapath: two-bank vector memory, sliding window, mean pipeline and result register.
module itps_dp #(
   parameter int MAX_LEN = itps_pkg::MAX_LEN_DEFAULT,
   parameter int IDX_W   = $clog2(MAX_LEN)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [itps_pkg::SAMPLE_W-1:0] req_sample,
   input  itps_pkg::cmd_type             cmd,
   input  logic [IDX_W-1:0]              ctl_idx,
   output itps_pkg::stat_type            stat,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [itps_pkg::SAMPLE_W-1:0] rsp_value,
   output logic [itps_pkg::RSUM_W-1:0]   rsp_running_sum,
   output logic                          rsp_overflow,
   output logic                          rsp_last_out
);
   import itps_pkg::*;

   localparam int ADDR_W = IDX_W + 1;

   // Vector memory, bank bit on top
   logic [SAMPLE_W-1:0] vec_mem [2**ADDR_W];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [SAMPLE_W-1:0] wr_data;

   // Sweep pipeline
   logic                s1_valid_ff, s1_out_ff, s1_lo_ff, s1_hi_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [SAMPLE_W-1:0] w0_ff, w1_ff, w2_ff;
   logic                s2_valid_ff, s2_lo_ff, s2_hi_ff;
   logic [IDX_W-1:0]    s2_idx_ff;
   logic [SUM3_W-1:0]   sum_in;
   logic                s3_valid_ff, s3_two_ff;
   logic [IDX_W-1:0]    s3_idx_ff;
   logic [SUM3_W-1:0]   s3_sum_ff;
   logic [PROD_W-1:0]   prod;
   logic [SAMPLE_W-1:0] mean;

   // Result side
   logic                ovf_ff, ovf_in;
   logic [RSUM_W-1:0]   run_sum_ff, run_sum_in;
   logic [RSUM_W-1:0]   sum_next;
   logic                emit_pend_ff, emit_last_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_value_ff;
   logic [RSUM_W-1:0]   rsp_sum_ff;
   logic                rsp_ovf_ff, rsp_last_ff;

   // Memory ports: load or sweep write, step or emit read
   assign mem_we  = cmd.load_wr || s3_valid_ff;
   assign wr_addr = cmd.load_wr ? {cmd.bank, ctl_idx} : {!cmd.bank, s3_idx_ff};
   assign wr_data = cmd.load_wr ? req_sample : mean;
   assign mem_re  = (cmd.step && !cmd.step_flush) || cmd.emit;
   assign rd_addr = {cmd.bank, ctl_idx};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vec_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= vec_mem[rd_addr];
      end
   end

   // Stage 1: step tags, result index trails the read index by one
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.step;
      end
      s1_out_ff <= !cmd.step_first;
      s1_lo_ff  <= (ctl_idx == IDX_W'(1)) && !cmd.step_flush;
      s1_hi_ff  <= cmd.step_flush;
      s1_idx_ff <= ctl_idx - IDX_W'(1);
   end

   // Stage 2: shift the window by one element
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_out_ff;
      end
      if (s1_valid_ff) begin
         w0_ff <= w1_ff;
         w1_ff <= w2_ff;
         w2_ff <= rd_data_ff;
      end
      s2_lo_ff  <= s1_lo_ff;
      s2_hi_ff  <= s1_hi_ff;
      s2_idx_ff <= s1_idx_ff;
   end

   // Neighborhood sum plus rounding bias
   always_comb begin
      priority if (s2_lo_ff) begin
         sum_in = SUM3_W'(w1_ff) + SUM3_W'(w2_ff) + SUM3_W'(1);
      end else if (s2_hi_ff) begin
         sum_in = SUM3_W'(w0_ff) + SUM3_W'(w1_ff) + SUM3_W'(1);
      end else begin
         sum_in = SUM3_W'(w0_ff) + SUM3_W'(w1_ff) + SUM3_W'(w2_ff) + SUM3_W'(1);
      end
   end

   // Stage 3: register sum, then halve or divide by three and write back
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_sum_ff <= sum_in;
      s3_two_ff <= s2_lo_ff || s2_hi_ff;
      s3_idx_ff <= s2_idx_ff;
   end

   assign prod = PROD_W'(s3_sum_ff) * PROD_W'(RECIP3);
   assign mean = s3_two_ff ? s3_sum_ff[SAMPLE_W:1] : prod[RECIP_SHIFT +: SAMPLE_W];

   // Result register, running sum and overflow flag
   assign sum_next = run_sum_ff + RSUM_W'(rd_data_ff);

   always_comb begin
      ovf_in     = ovf_ff || cmd.ovf_set;
      run_sum_in = run_sum_ff;
      if (emit_pend_ff) begin
         run_sum_in = emit_last_ff ? '0 : sum_next;
         if (emit_last_ff) begin
            ovf_in = 1'b0;
         end
      end
      rsp_valid_in = emit_pend_ff || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff       <= 1'b0;
         run_sum_ff   <= '0;
         emit_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ovf_ff       <= ovf_in;
         run_sum_ff   <= run_sum_in;
         emit_pend_ff <= cmd.emit;
         rsp_valid_ff <= rsp_valid_in;
      end
      emit_last_ff <= cmd.emit_last;
      if (emit_pend_ff) begin
         rsp_value_ff <= rd_data_ff;
         rsp_sum_ff   <= sum_next;
         rsp_ovf_ff   <= ovf_ff;
         rsp_last_ff  <= emit_last_ff;
      end
   end

   assign stat.pipe_busy = s1_valid_ff || s2_valid_ff || s3_valid_ff;
   assign stat.emit_ok   = !emit_pend_ff && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_running_sum = rsp_sum_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_last_out    = rsp_last_ff;

   // Checks
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_wr && s3_valid_ff))
      else $error("load write collides with sweep write");

   a_emit_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(s1_valid_ff || s2_valid_ff || s3_valid_ff))
      else $error("emit read while sweep pipeline busy");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      emit_pend_ff |-> !rsp_valid_ff)
      else $error("result beat would overwrite a held beat");

endmodule

/* rtl/iterated_three_point_smoothing_unit.sv */
// Top level of the iterated three-point smoothing unit.
// Load: one sample beat per cycle while req_stall is low; the beat marked last starts smoothing.
// Each sweep over n elements makes one memory read per element, then a flush step and a pipeline drain.
// Results: n beats; a new result read waits until the previous one has been registered from the memory read.
// After the last input beat all sweeps run (none for n < 2), then the results are read out.
// Reset clears control, counts and flags and sets sweep_count to 1; memory is not cleared.
module iterated_three_point_smoothing_unit #(
   parameter int MAX_LEN = itps_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [itps_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_last_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [itps_pkg::SAMPLE_W-1:0] rsp_value,
   output logic [itps_pkg::RSUM_W-1:0]   rsp_running_sum,
   output logic                          rsp_overflow,
   output logic                          rsp_last_out,
   input  logic                          csr_we,
   input  logic [itps_pkg::SWEEP_W-1:0]  csr_wdata
);
   import itps_pkg::*;

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   cmd_type          cmd;
   stat_type         stat;
   logic [IDX_W-1:0] ctl_idx;

   // Sequencer
   itps_ctrl #(
      .MAX_LEN (MAX_LEN),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_last_in (req_last_in),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .stat        (stat),
      .cmd         (cmd),
      .ctl_idx     (ctl_idx)
   );

   // Datapath
   itps_dp #(
      .MAX_LEN (MAX_LEN),
      .IDX_W   (IDX_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_sample      (req_sample),
      .cmd             (cmd),
      .ctl_idx         (ctl_idx),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_running_sum (rsp_running_sum),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_out    (rsp_last_out)
   );

endmodule

/* tb/sv/iterated_three_point_smoothing_unit_test.sv */
// Self-checking testbench for the iterated three-point smoothing unit.
`timescale 1ns / 1ps

module iterated_three_point_smoothing_unit_test;
   import itps_pkg::*;

   localparam int VEC_DEPTH   = MAX_LEN_DEFAULT;
   localparam int QUIET_LIMIT = 250000;
   localparam int HOLD_CYCLES = 600;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 23'd6553600;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } sample_beat_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic [RSUM_W-1:0]   running_sum;
      logic                overflow;
      logic                last;
   } smoothed_beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                req_last_in = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0] rsp_value;
   logic [RSUM_W-1:0]   rsp_running_sum;
   logic                rsp_overflow;
   logic                rsp_last_out;
   logic                csr_we = 1'b0;
   logic [SWEEP_W-1:0]  csr_wdata = '0;

   // Beats waiting to be offered and smoothed results waiting to arrive
   sample_beat_type   pending_beats[$];
   smoothed_beat_type smoothed_results[$];
   sample_beat_type   next_beat;
   smoothed_beat_type arrived;

   // Shadow state of the smoothing engine
   logic [SWEEP_W-1:0]  sweep_setting = SWEEP_RESET;
   logic [SAMPLE_W-1:0] smooth_vec [VEC_DEPTH];
   logic [SAMPLE_W-1:0] prev_vec   [VEC_DEPTH];
   int unsigned         stored_count = 0;
   logic                dropped_any = 1'b0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   bit          pressure_on = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;

   iterated_three_point_smoothing_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last_in     (req_last_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_running_sum (rsp_running_sum),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_out    (rsp_last_out),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Store one accepted sample; on the closing beat run the sweeps and queue the results
   task automatic smooth_beat(input logic [SAMPLE_W-1:0] s, input logic lst);
      int unsigned    n;
      int unsigned    acc;
      logic [RSUM_W-1:0] sum;
      smoothed_beat_type res;
      if (stored_count < VEC_DEPTH) begin
         smooth_vec[stored_count] = s;
         stored_count++;
      end else begin
         dropped_any = 1'b1;
      end
      if (!lst) return;
      n = stored_count;
      // a single element has no neighbor and passes through
      if (n >= 2) begin
         for (int k = 0; k < sweep_setting; k++) begin
            for (int i = 0; i < n; i++) prev_vec[i] = smooth_vec[i];
            acc = prev_vec[0] + prev_vec[1] + 1;
            smooth_vec[0] = SAMPLE_W'(acc >> 1);
            for (int i = 1; i + 1 < n; i++) begin
               acc = prev_vec[i-1] + prev_vec[i] + prev_vec[i+1] + 1;
               smooth_vec[i] = SAMPLE_W'(acc / 3);
            end
            acc = prev_vec[n-2] + prev_vec[n-1] + 1;
            smooth_vec[n-1] = SAMPLE_W'(acc >> 1);
         end
      end
      sum = '0;
      for (int i = 0; i < n; i++) begin
         sum = sum + RSUM_W'(smooth_vec[i]);
         res.value       = smooth_vec[i];
         res.running_sum = sum;
         res.overflow    = dropped_any;
         res.last        = (i + 1 == n);
         smoothed_results.push_back(res);
      end
      stored_count = 0;
      dropped_any  = 1'b0;
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Offer queued beats, idling at random; predict on every accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) smooth_beat(req_sample, req_last_in);
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = pending_beats.pop_front();
               req_valid   <= 1'b1;
               req_sample  <= next_beat.sample;
               req_last_in <= next_beat.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each result beat against the oldest prediction and drive the stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (smoothed_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got value %0d sum %0d",
                        $time, rsp_value, rsp_running_sum);
               mismatches++;
            end else begin
               arrived = smoothed_results.pop_front();
               check_field("value", 32'(arrived.value), 32'(rsp_value));
               check_field("running_sum", 32'(arrived.running_sum), 32'(rsp_running_sum));
               check_field("overflow", 32'(arrived.overflow), 32'(rsp_overflow));
               check_field("last_out", 32'(arrived.last), 32'(rsp_last_out));
            end
         end
         // hold off once for a long stretch so the block backs up
         if (pressure_on && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Abort when no beat moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_beat(input logic [SAMPLE_W-1:0] s, input logic lst);
      sample_beat_type b;
      b.sample = s;
      b.last   = lst;
      pending_beats.push_back(b);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(9))
         0: return '0;
         1: return FULL_SCALE;
         2: return SAMPLE_W'($urandom);
         default: return SAMPLE_W'($urandom_range(0, 32'(FULL_SCALE)));
      endcase
   endfunction

   task automatic add_vector(input int unsigned len);
      for (int i = 0; i < len; i++) add_beat(random_sample(), i + 1 == len);
   endtask

   // Mostly short vectors, now and then a long one
   task automatic add_random_vectors(input int unsigned budget, input int unsigned max_len);
      int unsigned count;
      int unsigned len;
      count = 0;
      while (count < budget) begin
         if ($urandom_range(4) == 0) len = $urandom_range(1, max_len);
         else len = $urandom_range(1, (max_len < 8) ? max_len : 8);
         add_vector(len);
         count += len;
      end
   endtask

   // Wait until every beat is out and every result is in, then let the block settle
   task automatic drain(input int unsigned settle);
      do @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || smoothed_results.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic start_phase(input logic [SWEEP_W-1:0] sweeps, input int unsigned send_pct,
                              input int unsigned recv_pct);
      drain(16);
      csr_we    <= 1'b1;
      csr_wdata <= sweeps;
      @(posedge clock);
      csr_we <= 1'b0;
      sweep_setting  = sweeps;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset sweep count: single elements, rounding ties, extremes, bit patterns
      add_beat(23'h7FFFFF, 1'b1);
      add_beat(23'h000000, 1'b1);
      add_beat(23'd1, 1'b0);
      add_beat(23'd0, 1'b1);
      add_beat(FULL_SCALE, 1'b0);
      add_beat(23'd0, 1'b0);
      add_beat(FULL_SCALE, 1'b1);
      add_beat(23'd2, 1'b0);
      add_beat(23'd0, 1'b0);
      add_beat(23'd0, 1'b0);
      add_beat(23'h555555, 1'b0);
      add_beat(23'h2AAAAA, 1'b1);
      add_beat(23'h7FFFFF, 1'b0);
      add_beat(23'h7FFFFF, 1'b0);
      add_beat(23'h7FFFFF, 1'b1);

      // Zero sweeps: vectors come back unchanged
      start_phase(10'd0, 0, 0);
      add_beat(23'h2AAAAA, 1'b0);
      add_beat(23'h555555, 1'b0);
      add_beat(FULL_SCALE, 1'b1);
      add_beat(23'h7FFFFF, 1'b1);
      add_random_vectors(15, 12);

      // Most sweeps: short vectors plus one full-length vector, sender idling
      start_phase(10'd1023, 54, 0);
      add_random_vectors(10, 3);
      add_vector(VEC_DEPTH);

      // Two sweeps, receiver stalling, one vector past capacity
      start_phase(10'd2, 0, 54);
      add_random_vectors(10, 16);
      add_vector(VEC_DEPTH + $urandom_range(1, 3));
      add_random_vectors(10, 16);

      // Random sweep count, both sides idling
      start_phase(10'($urandom_range(3, 40)), 33, 33);
      add_random_vectors(30, 20);

      // One sweep, long receiver hold-off while the sender keeps offering
      start_phase(10'd1, 0, 0);
      pressure_on = 1'b1;
      add_random_vectors(20, 8);
      add_random_vectors(10, 10);

      drain(40);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/itps_pkg.sv
rtl/itps_ctrl.sv
rtl/itps_dp.sv
rtl/iterated_three_point_smoothing_unit.sv
tb/sv/iterated_three_point_smoothing_unit_test.sv
